[design/mtd_pkg.sv]
// Shared types and constants for the multi-tap detector.
// Used by every module of the block; depends on nothing.
`default_nettype none

package mtd_pkg;

  localparam int TIME_W  = 32;
  localparam int LIMIT_W = 24;
  localparam int COUNT_W = 4;
  localparam int PHASE_W = 2;
  localparam int TRIG_W  = 2;
  localparam int CFG_INDEX_W = 2;

  localparam logic [PHASE_W-1:0] PHASE_IDLE            = 2'd0;
  localparam logic [PHASE_W-1:0] PHASE_RELEASE_PENDING = 2'd1;
  localparam logic [PHASE_W-1:0] PHASE_CLICK_PENDING   = 2'd2;

  localparam logic [TRIG_W-1:0] TRIG_NONE      = 2'd0;
  localparam logic [TRIG_W-1:0] TRIG_ONGOING   = 2'd1;
  localparam logic [TRIG_W-1:0] TRIG_TRIGGERED = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] CFG_TAP_TIME_LIMIT    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_TAP_SPACING_LIMIT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_TAPS_NEEDED       = 2'd2;

  localparam logic [LIMIT_W-1:0] TAP_TIME_LIMIT_RESET    = 24'd200000;
  localparam logic [LIMIT_W-1:0] TAP_SPACING_LIMIT_RESET = 24'd200000;
  localparam logic [COUNT_W-1:0] TAPS_NEEDED_RESET       = 4'd2;

  typedef struct packed {
    logic [LIMIT_W-1:0] tap_time_limit;
    logic [LIMIT_W-1:0] tap_spacing_limit;
    logic [COUNT_W-1:0] taps_needed;
  } cfg_t;

  typedef struct packed {
    logic              pressed;
    logic [TIME_W-1:0] now;
  } sample_t;

endpackage

`default_nettype wire

[design/mtd_config.sv]
// Configuration register bank of the multi-tap detector.
// Depends on mtd_pkg for the register indexes, widths and reset values.
`default_nettype none

module mtd_config (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_valid,
  input  wire logic [mtd_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [mtd_pkg::LIMIT_W-1:0]      cfg_data,
  output mtd_pkg::cfg_t                         cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tap_time_limit    <= mtd_pkg::TAP_TIME_LIMIT_RESET;
      cfg.tap_spacing_limit <= mtd_pkg::TAP_SPACING_LIMIT_RESET;
      cfg.taps_needed       <= mtd_pkg::TAPS_NEEDED_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        mtd_pkg::CFG_TAP_TIME_LIMIT:    cfg.tap_time_limit    <= cfg_data;
        mtd_pkg::CFG_TAP_SPACING_LIMIT: cfg.tap_spacing_limit <= cfg_data;
        mtd_pkg::CFG_TAPS_NEEDED: begin
          cfg.taps_needed <= cfg_data[mtd_pkg::COUNT_W-1:0];
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

[design/mtd_core.sv]
// Tap recognition state and per-sample decision logic.
// Depends on mtd_pkg for phase and trigger codes and the shared structs.
`default_nettype none

module mtd_core (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        fire,
  input  wire mtd_pkg::sample_t            sample,
  input  wire mtd_pkg::cfg_t               cfg,
  output logic [mtd_pkg::TRIG_W-1:0]       trigger_next
);

  logic [mtd_pkg::PHASE_W-1:0] phase, phase_next;
  logic [mtd_pkg::COUNT_W-1:0] tap_count, tap_count_next, count_inc;
  logic [mtd_pkg::TIME_W-1:0]  press_time, press_time_next;
  logic [mtd_pkg::TIME_W-1:0]  release_time, release_time_next;
  logic [mtd_pkg::TIME_W-1:0]  held, gap;
  logic                        tap_ok, gap_ok;

  assign held   = sample.now - press_time;
  assign gap    = sample.now - release_time;
  assign tap_ok = held <= {{(mtd_pkg::TIME_W-mtd_pkg::LIMIT_W){1'b0}}, cfg.tap_time_limit};
  assign gap_ok = gap <= {{(mtd_pkg::TIME_W-mtd_pkg::LIMIT_W){1'b0}}, cfg.tap_spacing_limit};
  assign count_inc = tap_count + 1'b1;

  always_comb begin
    phase_next        = phase;
    tap_count_next    = tap_count;
    press_time_next   = press_time;
    release_time_next = release_time;
    trigger_next      = mtd_pkg::TRIG_NONE;
    case (phase)
      mtd_pkg::PHASE_RELEASE_PENDING: begin
        if (sample.pressed) begin
          trigger_next = mtd_pkg::TRIG_ONGOING;
        end else if (tap_ok) begin
          if (count_inc >= cfg.taps_needed) begin
            phase_next     = mtd_pkg::PHASE_IDLE;
            tap_count_next = '0;
            trigger_next   = mtd_pkg::TRIG_TRIGGERED;
          end else begin
            phase_next        = mtd_pkg::PHASE_CLICK_PENDING;
            tap_count_next    = count_inc;
            release_time_next = sample.now;
            trigger_next      = mtd_pkg::TRIG_ONGOING;
          end
        end else begin
          phase_next     = mtd_pkg::PHASE_IDLE;
          tap_count_next = '0;
        end
      end
      mtd_pkg::PHASE_CLICK_PENDING: begin
        if (!sample.pressed) begin
          trigger_next = mtd_pkg::TRIG_ONGOING;
        end else if (gap_ok) begin
          phase_next      = mtd_pkg::PHASE_RELEASE_PENDING;
          press_time_next = sample.now;
          trigger_next    = mtd_pkg::TRIG_ONGOING;
        end else begin
          phase_next     = mtd_pkg::PHASE_IDLE;
          tap_count_next = '0;
        end
      end
      default: begin
        // The unused phase code behaves as idle.
        if (sample.pressed) begin
          phase_next      = mtd_pkg::PHASE_RELEASE_PENDING;
          press_time_next = sample.now;
          trigger_next    = mtd_pkg::TRIG_ONGOING;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= mtd_pkg::PHASE_IDLE;
      tap_count    <= '0;
      press_time   <= '0;
      release_time <= '0;
    end else if (fire) begin
      phase        <= phase_next;
      tap_count    <= tap_count_next;
      press_time   <= press_time_next;
      release_time <= release_time_next;
    end
  end

endmodule

`default_nettype wire

[design/multi_tap_detector.sv]
// Top level of the multi-tap detector: input register, decision core, result register.
// Depends on mtd_pkg, mtd_config and mtd_core.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+---------------------------
//   input    | in_valid / in_ready   | pressed, now
//   result   | out_valid / out_ready | trigger
//   config   | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// Each item waits in the input register while the core decides it; its result is
// registered into the result register as the item leaves, which a stalled result can delay;
// one item per cycle is sustained while the result is not stalled.
// The figure is set by the single state update per item in the decision core.
// A synchronous reset restores the default limits and returns the detector to idle.
// A stalled result holds the pipeline; the input register still takes an item
// whenever it is empty or moving on.
`default_nettype none

module multi_tap_detector (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic                             pressed,
  input  wire logic [mtd_pkg::TIME_W-1:0]       now,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [mtd_pkg::TRIG_W-1:0]            trigger,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [mtd_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [mtd_pkg::LIMIT_W-1:0]      cfg_data
);

  mtd_pkg::cfg_t              cfg;
  mtd_pkg::sample_t           sample;
  logic                       sample_valid;
  logic                       out_free;
  logic                       fire;
  logic [mtd_pkg::TRIG_W-1:0] trigger_next;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;
  assign fire      = sample_valid && out_free;
  assign in_ready  = !sample_valid || fire;

  mtd_config u_config (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mtd_core u_core (
    .clk          (clk),
    .rst          (rst),
    .fire         (fire),
    .sample       (sample),
    .cfg          (cfg),
    .trigger_next (trigger_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else if (in_ready) begin
      sample_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      sample.pressed <= pressed;
      sample.now     <= now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      trigger <= trigger_next;
    end
  end

endmodule

`default_nettype wire

[sim/tb_multi_tap_detector.sv]
`timescale 1ns / 1ps
// Testbench for multi_tap_detector: directed tap sequences and configuration extremes, then
// random runs under varied flow control, each result checked against a behavioural predictor.
// Depends on mtd_pkg and the multi_tap_detector design files.

module tb_multi_tap_detector;

  localparam int TIME_W      = mtd_pkg::TIME_W;
  localparam int LIMIT_W     = mtd_pkg::LIMIT_W;
  localparam int COUNT_W     = mtd_pkg::COUNT_W;
  localparam int PHASE_W     = mtd_pkg::PHASE_W;
  localparam int TRIG_W      = mtd_pkg::TRIG_W;
  localparam int CFG_INDEX_W = mtd_pkg::CFG_INDEX_W;

  localparam int LATENCY         = 2;
  localparam int CYCLE_LIMIT     = 300000;
  localparam int ITEMS_PER_PHASE = 100;

  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 2'd3;
  localparam logic [LIMIT_W-1:0]     LIMIT_MAX        = '1;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   in_valid  = 1'b0;
  logic                   in_ready;
  logic                   pressed   = 1'b0;
  logic [TIME_W-1:0]      now       = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [TRIG_W-1:0]      trigger;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [LIMIT_W-1:0]     cfg_data  = '0;

  multi_tap_detector dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .pressed   (pressed),
    .now       (now),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .trigger   (trigger),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  logic [LIMIT_W-1:0] time_limit    = mtd_pkg::TAP_TIME_LIMIT_RESET;
  logic [LIMIT_W-1:0] spacing_limit = mtd_pkg::TAP_SPACING_LIMIT_RESET;
  logic [COUNT_W-1:0] taps_target   = mtd_pkg::TAPS_NEEDED_RESET;
  logic [PHASE_W-1:0] run_phase     = mtd_pkg::PHASE_IDLE;
  logic [COUNT_W-1:0] taps_done     = '0;
  logic [TIME_W-1:0]  last_press    = '0;
  logic [TIME_W-1:0]  last_release  = '0;

  logic [TRIG_W-1:0] expected_triggers[$];
  logic [TIME_W-1:0] clock_us    = '0;
  int                error_count = 0;
  int                sent_count  = 0;
  int                idle_pct    = 0;
  int                stall_pct   = 0;
  int                cycle_count = 0;

  function automatic logic [TRIG_W-1:0] predict_trigger(input logic down,
                                                        input logic [TIME_W-1:0] stamp);
    logic [TRIG_W-1:0] res;
    logic [TIME_W-1:0] gap;
    res = mtd_pkg::TRIG_NONE;
    case (run_phase)
      mtd_pkg::PHASE_RELEASE_PENDING: begin
        gap = stamp - last_press;
        if (down) begin
          res = mtd_pkg::TRIG_ONGOING;
        end else if (gap <= time_limit) begin
          taps_done = taps_done + 1'b1;
          if (taps_done >= taps_target) begin
            run_phase = mtd_pkg::PHASE_IDLE;
            taps_done = '0;
            res = mtd_pkg::TRIG_TRIGGERED;
          end else begin
            run_phase = mtd_pkg::PHASE_CLICK_PENDING;
            last_release = stamp;
            res = mtd_pkg::TRIG_ONGOING;
          end
        end else begin
          run_phase = mtd_pkg::PHASE_IDLE;
          taps_done = '0;
        end
      end
      mtd_pkg::PHASE_CLICK_PENDING: begin
        gap = stamp - last_release;
        if (!down) begin
          res = mtd_pkg::TRIG_ONGOING;
        end else if (gap <= spacing_limit) begin
          run_phase = mtd_pkg::PHASE_RELEASE_PENDING;
          last_press = stamp;
          res = mtd_pkg::TRIG_ONGOING;
        end else begin
          run_phase = mtd_pkg::PHASE_IDLE;
          taps_done = '0;
        end
      end
      default: begin
        if (down) begin
          run_phase = mtd_pkg::PHASE_RELEASE_PENDING;
          last_press = stamp;
          res = mtd_pkg::TRIG_ONGOING;
        end
      end
    endcase
    return res;
  endfunction

  function automatic logic [TIME_W-1:0] pick_delay(input logic [LIMIT_W-1:0] limit,
                                                   input bit in_range);
    logic [TIME_W-1:0] d;
    if (in_range) begin
      case ($urandom_range(3))
        0: d = '0;
        1: d = TIME_W'(limit);
        default: d = $urandom_range(TIME_W'(limit));
      endcase
    end else if ($urandom_range(1) == 0) begin
      d = TIME_W'(limit) + 1;
    end else begin
      d = TIME_W'(limit) + 1 + $urandom_range(32'h7FFF_FFFF);
    end
    return d;
  endfunction

  function automatic logic [LIMIT_W-1:0] pick_limit();
    case ($urandom_range(4))
      0: return '0;
      1: return LIMIT_MAX;
      2: return mtd_pkg::TAP_TIME_LIMIT_RESET;
      default: return LIMIT_W'($urandom());
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    error_count++;
  endtask

  always @(posedge clk) begin : check_results
    logic [TRIG_W-1:0] want;
    out_ready <= ($urandom_range(99) >= stall_pct);
    if (!rst && out_valid && out_ready) begin
      if (expected_triggers.size() == 0) begin
        report_mismatch($sformatf("trigger %0d with no item pending", trigger));
      end else begin
        want = expected_triggers.pop_front();
        if (trigger !== want) begin
          report_mismatch($sformatf("trigger %0d, expected %0d", trigger, want));
        end
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("** multi_tap_detector: FAILED **");
    $finish;
  end

  task automatic send_sample(input logic down, input logic [TIME_W-1:0] stamp);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    pressed  <= down;
    now      <= stamp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_triggers.push_back(predict_trigger(down, stamp));
    sent_count++;
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_triggers.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [LIMIT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      mtd_pkg::CFG_TAP_TIME_LIMIT:    time_limit    = data;
      mtd_pkg::CFG_TAP_SPACING_LIMIT: spacing_limit = data;
      mtd_pkg::CFG_TAPS_NEEDED:       taps_target   = data[COUNT_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_tap_run(input int taps);
    logic [TIME_W-1:0] press_at;
    logic [TIME_W-1:0] hold;
    for (int k = 0; k < taps; k++) begin
      if (k > 0) begin
        clock_us = clock_us + pick_delay(spacing_limit, $urandom_range(19) != 0);
      end
      press_at = clock_us;
      send_sample(1'b1, press_at);
      hold = pick_delay(time_limit, $urandom_range(19) != 0);
      repeat ($urandom_range(2)) send_sample(1'b1, press_at + $urandom_range(hold));
      clock_us = press_at + hold;
      send_sample(1'b0, clock_us);
      repeat ($urandom_range(2)) begin
        send_sample(1'b0, clock_us + $urandom_range(TIME_W'(spacing_limit)));
      end
    end
  endtask

  task automatic run_random_phase(input int sender_pct, input int receiver_pct);
    int                 target;
    int                 taps;
    logic [LIMIT_W-1:0] tap_data;
    wait_for_results();
    idle_pct  = sender_pct;
    stall_pct = receiver_pct;
    tap_data = LIMIT_W'($urandom());
    if ($urandom_range(1) == 0) tap_data[COUNT_W-1:0] = COUNT_W'($urandom_range(4, 1));
    write_register(mtd_pkg::CFG_TAP_TIME_LIMIT, pick_limit());
    write_register(mtd_pkg::CFG_TAP_SPACING_LIMIT, pick_limit());
    write_register(mtd_pkg::CFG_TAPS_NEEDED, tap_data);
    if ($urandom_range(2) == 0) write_register(CFG_UNUSED_INDEX, LIMIT_W'($urandom()));
    target = sent_count + ITEMS_PER_PHASE;
    while (sent_count < target) begin
      case ($urandom_range(9))
        0, 1: begin
          repeat ($urandom_range(4, 1)) send_sample(1'($urandom_range(1)), $urandom());
        end
        2: begin
          if ($urandom_range(3) == 0) wait_for_results();
          clock_us = 32'hFFFF_FFFF - $urandom_range(32'h00FF_FFFF);
        end
        default: begin
          taps = (taps_target == 0) ? 1 : int'(taps_target);
          if ($urandom_range(3) == 0) taps = $urandom_range(taps, 1);
          clock_us = clock_us + $urandom_range(1000);
          send_tap_run(taps);
        end
      endcase
    end
  endtask

  task automatic test_default_limits();
    send_sample(1'b0, '0);
    send_sample(1'b1, 32'hFFFF_FFF0);
    send_sample(1'b1, 32'h0000_0010);
    send_sample(1'b0, 32'hFFFF_FFF0 + TIME_W'(mtd_pkg::TAP_TIME_LIMIT_RESET));
    send_sample(1'b0, 32'hFFFF_FFF0 + TIME_W'(mtd_pkg::TAP_TIME_LIMIT_RESET) + 1);
    send_sample(1'b1, 32'hFFFF_FFF0 + 2 * TIME_W'(mtd_pkg::TAP_TIME_LIMIT_RESET));
    send_sample(1'b0, 32'hFFFF_FFF0 + 2 * TIME_W'(mtd_pkg::TAP_TIME_LIMIT_RESET));
    // A press held one microsecond too long, across the wrap of the timer.
    send_sample(1'b1, '1);
    send_sample(1'b0, 32'hFFFF_FFFF + TIME_W'(mtd_pkg::TAP_TIME_LIMIT_RESET) + 1);
    // A gap one microsecond too long between release and the next press.
    send_sample(1'b1, 32'd1000);
    send_sample(1'b0, 32'd1000);
    send_sample(1'b1, 32'd1001 + TIME_W'(mtd_pkg::TAP_SPACING_LIMIT_RESET));
    send_sample(1'b0, 32'd5000);
  endtask

  task automatic test_config_extremes();
    wait_for_results();
    write_register(mtd_pkg::CFG_TAPS_NEEDED, 24'hFFFFF0);
    write_register(mtd_pkg::CFG_TAP_TIME_LIMIT, LIMIT_MAX);
    write_register(mtd_pkg::CFG_TAP_SPACING_LIMIT, LIMIT_MAX);
    send_sample(1'b1, '0);
    send_sample(1'b0, TIME_W'(LIMIT_MAX));
    wait_for_results();
    write_register(mtd_pkg::CFG_TAPS_NEEDED, 24'h00000F);
    write_register(mtd_pkg::CFG_TAP_TIME_LIMIT, '0);
    write_register(mtd_pkg::CFG_TAP_SPACING_LIMIT, '0);
    write_register(CFG_UNUSED_INDEX, LIMIT_MAX);
    send_sample(1'b1, 32'd5);
    send_sample(1'b0, 32'd5);
    send_sample(1'b1, 32'd5);
    send_sample(1'b0, 32'd6);
    send_sample(1'b1, 32'd7);
    send_sample(1'b0, 32'd7);
    send_sample(1'b1, 32'd8);
  endtask

  task automatic test_random_runs();
    run_random_phase(0, 0);
    run_random_phase(82, 0);
    run_random_phase(0, 82);
    run_random_phase(12, 12);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_default_limits();
    test_config_extremes();
    test_random_runs();
    wait_for_results();
    repeat (LATENCY * 4) @(posedge clk);
    if (error_count == 0) begin
      $display("** multi_tap_detector: PASSED **");
    end else begin
      $display("** multi_tap_detector: FAILED **");
    end
    $finish;
  end

endmodule

[multi_tap_detector.f]
design/mtd_pkg.sv
design/mtd_config.sv
design/mtd_core.sv
design/multi_tap_detector.sv
sim/tb_multi_tap_detector.sv
